[rtl/core/mosf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mosf_pkg
// Shared types and constants for the mesh outlier smoothing filter.
// ----------------------------------------------------------------------------
package mosf_pkg;

  // Height word and window arithmetic widths.
  localparam int unsigned HW      = 16;
  localparam int unsigned SUM_W   = 20;   // Eight neighbours of 16 bits, signed.
  localparam int unsigned DIV_W   = 4;    // Neighbour count, 0..8.
  localparam int unsigned DCNT_W  = $clog2(SUM_W);

  // Register map, indexed by paddr[3:2].
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_EDGE  = 2'd2;
  localparam logic [1:0] REG_INNER = 2'd3;

  localparam logic [3:0]  SIZE_RESET  = 4'd8;
  localparam logic [15:0] EDGE_RESET  = 16'd350;
  localparam logic [15:0] INNER_RESET = 16'd300;
  localparam logic [15:0] THRESH_MIN  = 16'd21;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic win_init;
    logic rd;
    logic acc;
    logic div_init;
    logic div_step;
    logic res;
    logic next_point;
  } mosf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic load_done;
    logic win_last;
    logic div_last;
    logic last_point;
  } mosf_sts_t;

endpackage
`default_nettype wire

[rtl/core/mosf_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mosf_cfg
// Register file behind the APB-style port, with the grid size clamped for use.
// ----------------------------------------------------------------------------
module mosf_cfg #(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned MAX_COLS = 8,
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1),
  localparam int unsigned CCW = $clog2(MAX_COLS + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mosf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mosf_pkg::PDATA_W-1:0] pwdata,
  output logic      [mosf_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  output logic      [RCW-1:0]               rows,
  output logic      [CCW-1:0]               cols,
  output logic      [15:0]                  edge_threshold,
  output logic      [15:0]                  inner_threshold
);
  import mosf_pkg::*;

  logic [3:0] rows_used;
  logic [3:0] cols_used;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used       <= SIZE_RESET;
      cols_used       <= SIZE_RESET;
      edge_threshold  <= EDGE_RESET;
      inner_threshold <= INNER_RESET;
    end else if (wr) begin
      case (idx)
        REG_ROWS: rows_used <= pwdata[3:0];
        REG_COLS: cols_used <= pwdata[3:0];
        REG_EDGE: begin
          if (pwdata[15:0] >= THRESH_MIN) edge_threshold <= pwdata[15:0];
        end
        REG_INNER: begin
          if (pwdata[15:0] >= THRESH_MIN) inner_threshold <= pwdata[15:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROWS:  prdata = {28'd0, rows_used};
      REG_COLS:  prdata = {28'd0, cols_used};
      REG_EDGE:  prdata = {16'd0, edge_threshold};
      REG_INNER: prdata = {16'd0, inner_threshold};
      default:   prdata = '0;
    endcase
  end

  // A size of zero counts as one; a size above the maximum saturates.
  always_comb begin
    if (rows_used == 4'd0)              rows = RCW'(1);
    else if (rows_used > 4'(MAX_ROWS))  rows = RCW'(MAX_ROWS);
    else                                rows = rows_used[RCW-1:0];
    if (cols_used == 4'd0)              cols = CCW'(1);
    else if (cols_used > 4'(MAX_COLS))  cols = CCW'(MAX_COLS);
    else                                cols = cols_used[CCW-1:0];
  end

endmodule
`default_nettype wire

[rtl/core/mosf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mosf_ctrl
// Sequencer: loads points, then walks each window, divides and emits.
// ----------------------------------------------------------------------------
module mosf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                height_valid,
  output logic                     height_stall,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output mosf_pkg::mosf_cmd_t      cmd,
  input  wire mosf_pkg::mosf_sts_t sts
);
  import mosf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WIN_INIT, ST_RD, ST_ACC, ST_DIV_INIT, ST_DIV, ST_RES, ST_OUT
  } state_t;

  state_t state;

  assign height_stall = (state != ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == ST_IDLE) & height_valid;
    cmd.win_init   = (state == ST_WIN_INIT);
    cmd.rd         = (state == ST_RD);
    cmd.acc        = (state == ST_ACC);
    cmd.div_init   = (state == ST_DIV_INIT);
    cmd.div_step   = (state == ST_DIV);
    cmd.res        = (state == ST_RES);
    cmd.next_point = (state == ST_OUT) & ~result_stall & ~sts.last_point;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (height_valid && sts.load_done) state <= ST_WIN_INIT;
        end
        ST_WIN_INIT: state <= ST_RD;
        ST_RD:       state <= ST_ACC;
        ST_ACC: begin
          state <= sts.win_last ? ST_DIV_INIT : ST_RD;
        end
        ST_DIV_INIT: state <= ST_DIV;
        ST_DIV: begin
          if (sts.div_last) state <= ST_RES;
        end
        ST_RES: begin
          state        <= ST_OUT;
          result_valid <= 1'b1;
        end
        ST_OUT: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            state        <= sts.last_point ? ST_IDLE : ST_WIN_INIT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/mosf_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mosf_dp
// Datapath: grid store, window walk, neighbour sum, serial divider and
// the threshold decision.
// ----------------------------------------------------------------------------
module mosf_dp #(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned MAX_COLS = 8,
  localparam int unsigned RCW   = $clog2(MAX_ROWS + 1),
  localparam int unsigned CCW   = $clog2(MAX_COLS + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mosf_pkg::mosf_cmd_t        cmd,
  output mosf_pkg::mosf_sts_t             sts,
  input  wire logic [RCW-1:0]             rows,
  input  wire logic [CCW-1:0]             cols,
  input  wire logic [15:0]                edge_threshold,
  input  wire logic [15:0]                inner_threshold,
  input  wire logic signed [mosf_pkg::HW-1:0] height,
  output logic signed [mosf_pkg::HW-1:0]  filtered_height,
  output logic                            was_replaced,
  output logic                            last_result
);
  import mosf_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic signed [HW-1:0] mem [DEPTH];
  logic signed [HW-1:0] rdata;

  logic [CW-1:0]  load_count;
  logic [CW-1:0]  lc_inc;
  logic [CW-1:0]  total;
  logic [RIW-1:0] r, m, r0, r1;
  logic [CIW-1:0] c, k, c0, c1;
  logic [RCW-1:0] rlast;
  logic [CCW-1:0] clast;
  logic           r_end, c_end;
  logic [1:0]     nr, nc;
  logic [DIV_W-1:0] dvs;
  logic [CW-1:0]  addr_full;
  logic [AW-1:0]  raddr;

  logic signed [SUM_W-1:0] sum;
  logic signed [HW-1:0]    centre;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        num;
  logic [DIV_W-1:0]        rem;
  logic [DIV_W:0]          trial;
  logic [DCNT_W-1:0]       div_cnt;
  logic                    neg;

  logic signed [HW:0]   mean;
  logic signed [HW+1:0] diff;
  logic [HW:0]          adiff;
  logic                 border;
  logic [15:0]          thr;
  logic                 repl;

  // Grid geometry around the current point.
  assign rlast  = rows - RCW'(1);
  assign clast  = cols - CCW'(1);
  assign r_end  = (RCW'(r) == rlast);
  assign c_end  = (CCW'(c) == clast);
  assign r0     = (r != '0) ? r - RIW'(1) : '0;
  assign r1     = r_end ? r : r + RIW'(1);
  assign c0     = (c != '0) ? c - CIW'(1) : '0;
  assign c1     = c_end ? c : c + CIW'(1);
  assign nr     = 2'd1 + {1'b0, (r != '0)} + {1'b0, ~r_end};
  assign nc     = 2'd1 + {1'b0, (c != '0)} + {1'b0, ~c_end};
  assign dvs    = DIV_W'(DIV_W'(nr) * DIV_W'(nc)) - DIV_W'(1);
  assign border = (r == '0) | (c == '0) | r_end | c_end;

  assign total     = CW'(rows) * CW'(cols);
  assign lc_inc    = load_count + CW'(1);
  assign addr_full = CW'(m) * CW'(cols) + CW'(k);
  assign raddr     = addr_full[AW-1:0];

  assign sts.load_done  = (lc_inc >= total);
  assign sts.win_last   = (m == r1) & (k == c1);
  assign sts.div_last   = (div_cnt == '0);
  assign sts.last_point = r_end & c_end;

  // Grid store.
  always_ff @(posedge clk) begin
    if (cmd.load) mem[load_count[AW-1:0]] <= height;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata <= mem[raddr];
  end

  // Load counter and point position.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      r          <= '0;
      c          <= '0;
    end else begin
      if (cmd.load) begin
        if (sts.load_done) begin
          load_count <= '0;
          r          <= '0;
          c          <= '0;
        end else begin
          load_count <= lc_inc;
        end
      end
      if (cmd.next_point) begin
        if (c_end) begin
          c <= '0;
          r <= r + RIW'(1);
        end else begin
          c <= c + CIW'(1);
        end
      end
    end
  end

  // Window walk and neighbour sum; the centre is kept aside.
  always_ff @(posedge clk) begin
    if (cmd.win_init) begin
      m   <= r0;
      k   <= c0;
      sum <= '0;
    end else if (cmd.acc) begin
      if (m == r && k == c) centre <= rdata;
      else                  sum    <= sum + SUM_W'(rdata);
      if (k == c1) begin
        k <= c0;
        m <= m + RIW'(1);
      end else begin
        k <= k + CIW'(1);
      end
    end
  end

  // Restoring divider, one quotient bit a cycle, on the rounded magnitude.
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign trial   = {rem, num[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg     <= sum[SUM_W-1];
      num     <= sum_mag + SUM_W'(dvs >> 1);
      rem     <= '0;
      div_cnt <= DCNT_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DCNT_W'(1);
      if (trial >= {1'b0, dvs}) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
        num <= {num[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_W-1:0];
        num <= {num[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Decision: a lone point keeps itself as the mean.
  always_comb begin
    if (dvs == '0)  mean = (HW+1)'(centre);
    else if (neg)   mean = -$signed({1'b0, num[HW-1:0]});
    else            mean = $signed({1'b0, num[HW-1:0]});
    diff  = (HW+2)'(mean) - (HW+2)'(centre);
    adiff = diff[HW+1] ? (HW+1)'(-diff) : (HW+1)'(diff);
    thr   = border ? edge_threshold : inner_threshold;
    repl  = (adiff > {1'b0, thr});
  end

  always_ff @(posedge clk) begin
    if (cmd.res) begin
      filtered_height <= repl ? mean[HW-1:0] : centre;
      was_replaced    <= repl;
      last_result     <= sts.last_point;
    end
  end

endmodule
`default_nettype wire

[rtl/core/mesh_outlier_smoothing_filter.sv]
`default_nettype none
// Loading takes one point per cycle while idle; the point that completes the grid starts
// emission. Each result then needs one store read and one accumulate per window point (1 to 9
// points) through the single store port, then a pass through the serial divider. A result
// held by result_stall waits in the output register; loading resumes after the last result
// is taken. Reset restores the default registers and the load counter; the grid store is not
// cleared.
// ----------------------------------------------------------------------------
// mesh_outlier_smoothing_filter
// Replaces outlier heights in a loaded grid by the rounded mean of their
// neighbours in the clamped 3x3 window, with separate border and interior limits.
// ----------------------------------------------------------------------------
module mesh_outlier_smoothing_filter #(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned MAX_COLS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration port.
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mosf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mosf_pkg::PDATA_W-1:0] pwdata,
  output logic      [mosf_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  // Height requests, one grid point each, row-major.
  input  wire logic                         height_valid,
  output logic                              height_stall,
  input  wire logic signed [15:0]           height,
  // Result requests, one per grid point, row-major.
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic signed [15:0]                filtered_height,
  output logic                              was_replaced,
  output logic                              last_result
);
  import mosf_pkg::*;

  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW = $clog2(MAX_COLS + 1);

  // Effective grid size and thresholds from the register file.
  logic [RCW-1:0] rows;
  logic [CCW-1:0] cols;
  logic [15:0]    edge_threshold;
  logic [15:0]    inner_threshold;

  // The controller sequences the datapath purely through these two groups.
  mosf_cmd_t cmd;
  mosf_sts_t sts;

  mosf_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .rows            (rows),
    .cols            (cols),
    .edge_threshold  (edge_threshold),
    .inner_threshold (inner_threshold)
  );

  // Loading is accepted only while the controller is idle; during emission
  // each point walks its window, divides, and presents one result request.
  mosf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .height_valid (height_valid),
    .height_stall (height_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  // All means are taken from the stored, unmodified heights, so replacing a
  // point never affects the decision for its neighbours.
  mosf_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .rows            (rows),
    .cols            (cols),
    .edge_threshold  (edge_threshold),
    .inner_threshold (inner_threshold),
    .height          (height),
    .filtered_height (filtered_height),
    .was_replaced    (was_replaced),
    .last_result     (last_result)
  );

endmodule
`default_nettype wire
